FILE: rtl/modexp_pkg.sv
// shared constants and types for the modular exponentiation block
`default_nettype none

package modexp_pkg;

    // fixed width of every port field
    localparam int FIELD_WIDTH = 32;

    // default operand width used for all arithmetic
    localparam int OPERAND_WIDTH_DEFAULT = 32;

    // modulus register value after reset
    localparam logic [FIELD_WIDTH-1:0] MODULUS_RESET = 32'd143;

    // status of the shared modular multiplier
    typedef struct packed {
        logic busy;
        logic done;
    } mul_status_t;

endpackage

`default_nettype wire

FILE: rtl/modular_exponentiation_top.sv
// modular exponentiation by right-to-left square and multiply
//
//  channel   direction  handshake              payload
//  in        request    in_valid / in_ready    base, exponent
//  out       result     out_valid / out_ready  power_residue
//  cfg       write      cfg_wr_en              cfg_wr_data (modulus)
//
// each modular product is computed in the shared bit-serial multiplier
// the base reduction is one pass through the multiplier; exponent zero gives 1 after it
// reset is asynchronous, active low, and sets the modulus to 143; no request in flight
// in_ready is high only while idle; a new result waits in S_FIN while the output is held
`default_nettype none

module modular_exponentiation_top
    import modexp_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEFAULT
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [FIELD_WIDTH-1:0] base,
    input  wire logic [FIELD_WIDTH-1:0] exponent,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [FIELD_WIDTH-1:0]      power_residue,
    input  wire logic                   cfg_wr_en,
    input  wire logic [FIELD_WIDTH-1:0] cfg_wr_data
);

    localparam int W = OPERAND_WIDTH;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RED,
        S_NEXT,
        S_MUL,
        S_SQR,
        S_FIN
    } state_t;

    state_t                 state_reg;
    logic [FIELD_WIDTH-1:0] modulus_reg;
    logic [W-1:0]           base_reg;
    logic [W-1:0]           exp_reg;
    logic [W-1:0]           acc_reg;
    logic [W-1:0]           op_a_reg;
    logic [W-1:0]           op_b_reg;
    logic                   mul_start_reg;
    logic                   out_valid_reg;
    logic [W-1:0]           result_reg;

    mul_status_t            mul_status;
    logic [W-1:0]           mul_product;

    // modulus configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= MODULUS_RESET;
        end
        else if (cfg_wr_en)
        begin
            modulus_reg <= cfg_wr_data;
        end
    end

    // shared modular multiplier
    modexp_mul #(
        .OPERAND_WIDTH (W)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start_reg),
        .op_a    (op_a_reg),
        .op_b    (op_b_reg),
        .modulus (modulus_reg[W-1:0]),
        .status  (mul_status),
        .product (mul_product)
    );

    // sequencer: reduce base, then per exponent bit multiply if the bit is set, and square
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mul_start_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            base_reg      <= '0;
            exp_reg       <= '0;
            acc_reg       <= '0;
            op_a_reg      <= '0;
            op_b_reg      <= '0;
            result_reg    <= '0;
        end
        else
        begin
            // result taken; S_FIN decides for itself
            if (out_valid_reg && out_ready && state_reg != S_FIN)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_a_reg      <= W'(1);
                        op_b_reg      <= base[W-1:0];
                        exp_reg       <= exponent[W-1:0];
                        acc_reg       <= W'(1);
                        mul_start_reg <= 1'b1;
                        state_reg     <= S_RED;
                    end
                    else
                    begin
                        mul_start_reg <= 1'b0;
                    end
                end
                S_RED:
                begin
                    mul_start_reg <= 1'b0;
                    if (mul_status.done)
                    begin
                        base_reg  <= mul_product;
                        state_reg <= S_NEXT;
                    end
                end
                S_NEXT:
                begin
                    if (exp_reg == '0)
                    begin
                        mul_start_reg <= 1'b0;
                        state_reg     <= S_FIN;
                    end
                    else if (exp_reg[0])
                    begin
                        op_a_reg      <= acc_reg;
                        op_b_reg      <= base_reg;
                        mul_start_reg <= 1'b1;
                        state_reg     <= S_MUL;
                    end
                    else
                    begin
                        op_a_reg      <= base_reg;
                        op_b_reg      <= base_reg;
                        mul_start_reg <= 1'b1;
                        state_reg     <= S_SQR;
                    end
                end
                S_MUL:
                begin
                    if (mul_status.done)
                    begin
                        acc_reg       <= mul_product;
                        op_a_reg      <= base_reg;
                        op_b_reg      <= base_reg;
                        mul_start_reg <= 1'b1;
                        state_reg     <= S_SQR;
                    end
                    else
                    begin
                        mul_start_reg <= 1'b0;
                    end
                end
                S_SQR:
                begin
                    mul_start_reg <= 1'b0;
                    if (mul_status.done)
                    begin
                        base_reg  <= mul_product;
                        exp_reg   <= exp_reg >> 1;
                        state_reg <= S_NEXT;
                    end
                end
                S_FIN:
                begin
                    mul_start_reg <= 1'b0;
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        result_reg    <= acc_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    mul_start_reg <= 1'b0;
                    state_reg     <= S_IDLE;
                end
            endcase
        end
    end

    // port drive
    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign power_residue = FIELD_WIDTH'(result_reg);

    // accepted request launches the base reduction on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (mul_start_reg && state_reg == S_RED))
        else $error("request accepted without launching base reduction");

    // multiplier only runs while the sequencer waits on it
    assert property (@(posedge clk) disable iff (!rst_n)
        mul_status.busy |->
            (state_reg == S_RED || state_reg == S_MUL || state_reg == S_SQR))
        else $error("multiplier busy outside a multiply phase");

    // a start never lands on a running multiplier
    assert property (@(posedge clk) disable iff (!rst_n)
        mul_start_reg |-> !mul_status.busy)
        else $error("multiplier started while busy");

    // a pending result is not overwritten before it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(result_reg)))
        else $error("pending result lost");

endmodule

`default_nettype wire

FILE: rtl/modexp_mul.sv
// bit-serial modular multiplier, one multiplier bit per cycle, msb first
`default_nettype none

module modexp_mul
    import modexp_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEFAULT
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic [OPERAND_WIDTH-1:0] op_a,
    input  wire logic [OPERAND_WIDTH-1:0] op_b,
    input  wire logic [OPERAND_WIDTH-1:0] modulus,
    output mul_status_t                   status,
    output logic [OPERAND_WIDTH-1:0]      product
);

    localparam int W  = OPERAND_WIDTH;
    localparam int CW = $clog2(W);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [W-1:0]  a_reg;
    logic [W-1:0]  ser_reg;
    logic [W-1:0]  acc_reg;
    logic [W-1:0]  acc_next;

    logic [W+1:0]  sum;
    logic [W+1:0]  mod_x1;
    logic [W+1:0]  mod_x2;

    // one step: acc = 2*acc + bit*a, then bring back below the modulus (a zero modulus wraps at W bits)
    always_comb
    begin
        sum    = {1'b0, acc_reg, 1'b0} + {2'b00, ({W{ser_reg[W-1]}} & a_reg)};
        mod_x1 = {2'b00, modulus};
        mod_x2 = {1'b0, modulus, 1'b0};
        if (modulus == '0)
        begin
            acc_next = sum[W-1:0];
        end
        else if (sum >= mod_x2)
        begin
            acc_next = W'(sum - mod_x2);
        end
        else if (sum >= mod_x1)
        begin
            acc_next = W'(sum - mod_x1);
        end
        else
        begin
            acc_next = sum[W-1:0];
        end
    end

    // step counter and control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // operand capture and accumulator datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= op_a;
            ser_reg <= op_b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            ser_reg <= {ser_reg[W-2:0], 1'b0};
            acc_reg <= acc_next;
        end
    end

    assign status  = '{busy: busy_reg, done: done_reg};
    assign product = acc_reg;

endmodule

`default_nettype wire

FILE: sim/modular_exponentiation_top_tb.sv
// self-checking testbench for the modular exponentiation top level
`timescale 1ns / 1ps

module modular_exponentiation_top_tb
    import modexp_pkg::*;
();

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 6;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_OFF       = 8;
    localparam int DRAIN_CYCLES   = 64;
    localparam int PHASE_ITEMS    = 70;

    // expected residues in request order, with a private copy of the modulus
    class residue_scoreboard;
        logic [FIELD_WIDTH-1:0] modulus;
        logic [FIELD_WIDTH-1:0] pending_residues[$];
        int mismatches;
        int checked;
        int requests;

        function new();
            modulus    = MODULUS_RESET;
            mismatches = 0;
            checked    = 0;
            requests   = 0;
        endfunction

        function void set_modulus(input logic [FIELD_WIDTH-1:0] value);
            modulus = value;
        endfunction

        // a zero modulus means wrap at the operand width
        function logic [63:0] reduce(input logic [63:0] value);
            if (modulus == '0)
                return value & 64'h0000_0000_FFFF_FFFF;
            return value % {32'd0, modulus};
        endfunction

        // right-to-left square and multiply
        function logic [FIELD_WIDTH-1:0] power_mod(input logic [FIELD_WIDTH-1:0] b,
                                                   input logic [FIELD_WIDTH-1:0] e);
            logic [63:0] acc;
            logic [63:0] running;
            logic [FIELD_WIDTH-1:0] bits;
            running = reduce({32'd0, b});
            acc     = 64'd1;
            bits    = e;
            while (bits != '0)
            begin
                if (bits[0])
                    acc = reduce(acc * running);
                bits    = bits >> 1;
                running = reduce(running * running);
            end
            return acc[FIELD_WIDTH-1:0];
        endfunction

        function void note_request(input logic [FIELD_WIDTH-1:0] b,
                                   input logic [FIELD_WIDTH-1:0] e);
            pending_residues = {pending_residues, power_mod(b, e)};
            requests++;
        endfunction

        function void check_residue(input logic [FIELD_WIDTH-1:0] actual);
            logic [FIELD_WIDTH-1:0] expected;
            if (pending_residues.size() == 0)
            begin
                $error("power_residue with no request pending: actual %0h", actual);
                mismatches++;
                return;
            end
            expected = pending_residues.pop_front();
            checked++;
            if (actual !== expected)
            begin
                $error("power_residue mismatch: expected %0h, actual %0h", expected, actual);
                mismatches++;
            end
        endfunction

        function int pending_count();
            return pending_residues.size();
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic [FIELD_WIDTH-1:0] base;
    logic [FIELD_WIDTH-1:0] exponent;
    logic                   out_valid;
    logic                   out_ready;
    logic [FIELD_WIDTH-1:0] power_residue;
    logic                   cfg_wr_en;
    logic [FIELD_WIDTH-1:0] cfg_wr_data;

    residue_scoreboard sb = new();
    bit idle_on = 1'b1;
    int settings_used = 1;
    int idle_cycles = 0;

    modular_exponentiation_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .base          (base),
        .exponent      (exponent),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .power_residue (power_residue),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #CLK_HALF;
        clk = 1'b1;
        #CLK_HALF;
    end

    // result side stalls in random bursts while idle_on is set
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 10) - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // result monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_ready)
            sb.check_residue(power_residue);
        if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready) || cfg_wr_en)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("modular_exponentiation_top_tb: FAIL");
            $finish;
        end
    end

    // present one request, with an occasional random gap first, and wait for acceptance
    task automatic send_request(input logic [FIELD_WIDTH-1:0] b,
                                input logic [FIELD_WIDTH-1:0] e);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 10);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        base     <= b;
        exponent <= e;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        sb.note_request(b, e);
    endtask

    // stop requesting and wait until every expected residue has come back
    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (sb.pending_count() != 0)
            @(posedge clk);
    endtask

    task automatic write_modulus(input logic [FIELD_WIDTH-1:0] value);
        repeat (HOLD_OFF) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_modulus(value);
        settings_used++;
    endtask

    // random requests, half of them with short exponents to keep the run brief
    task automatic run_random_phase(input int count, input int pause_at);
        logic [FIELD_WIDTH-1:0] b;
        logic [FIELD_WIDTH-1:0] e;
        logic [FIELD_WIDTH-1:0] m;
        int sel;
        for (int n = 0; n < count; n++)
        begin
            m   = sb.modulus;
            sel = $urandom_range(0, 19);
            if (sel < 5)
                e = $urandom();
            else if (sel < 15)
                e = $urandom() & ((32'd1 << $urandom_range(1, 12)) - 32'd1);
            else if (sel == 15)
                e = '0;
            else if (sel == 16)
                e = 32'd1;
            else if (sel == 17)
                e = 32'hFFFF_FFFF;
            else
                e = 32'd1 << $urandom_range(0, 31);
            case ($urandom_range(0, 9))
                0:       b = '0;
                1:       b = 32'd1;
                2:       b = m - 32'd1;
                3:       b = m;
                4:       b = m + $urandom_range(1, 100);
                5:       b = 32'hFFFF_FFFF;
                default: b = $urandom();
            endcase
            if (n == pause_at)
                wait_for_results();
            send_request(b, e);
        end
    endtask

    // main sequence
    initial
    begin
        logic [63:0] directed[$];
        logic [FIELD_WIDTH-1:0] moduli[$];
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        base        <= '0;
        exponent    <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset modulus: zero operands, reduction edges, top exponent bit
        directed = '{ {32'd0, 32'd0}, {32'd0, 32'd1}, {32'd1, 32'hFFFF_FFFF},
                      {32'hFFFF_FFFF, 32'd0}, {32'hFFFF_FFFF, 32'hFFFF_FFFF},
                      {32'd142, 32'd2}, {32'd143, 32'd5}, {32'd144, 32'd3},
                      {32'd2, 32'd10}, {32'd12, 32'h8000_0000}, {32'hFFFF_FFFF, 32'd1} };
        foreach (directed[i])
            send_request(directed[i][63:32], directed[i][31:0]);
        wait_for_results();

        // modulus of one: zero exponent still gives one, otherwise zero
        write_modulus(32'd1);
        directed = '{ {32'd0, 32'd0}, {32'd5, 32'd0}, {32'hFFFF_FFFF, 32'hFFFF_FFFF},
                      {32'd7, 32'd1} };
        foreach (directed[i])
            send_request(directed[i][63:32], directed[i][31:0]);
        wait_for_results();

        // largest modulus with largest operands
        write_modulus(32'hFFFF_FFFF);
        directed = '{ {32'hFFFF_FFFF, 32'hFFFF_FFFF}, {32'hFFFF_FFFE, 32'd2},
                      {32'hFFFF_FFFE, 32'hFFFF_FFFF}, {32'h8000_0000, 32'd2},
                      {32'hFFFF_FFFF, 32'd1}, {32'd0, 32'd0} };
        foreach (directed[i])
            send_request(directed[i][63:32], directed[i][31:0]);
        wait_for_results();

        // random phases over a spread of moduli, never zero
        moduli = '{ 32'hFFFF_FFFB, 32'd2, $urandom() | 32'd1, 32'd1,
                    ($urandom() & 32'h0000_FFFF) | 32'd3, 32'h8000_0000,
                    32'hFFFF_FFFF, $urandom() | 32'h0000_0100 };
        foreach (moduli[p])
        begin
            write_modulus(moduli[p]);
            if (p == moduli.size() - 1)
                idle_on = 1'b0;
            run_random_phase(PHASE_ITEMS, (p == 2) ? PHASE_ITEMS / 2 : -1);
            wait_for_results();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("ran %0d requests under %0d modulus settings, %0d residues compared",
                 sb.requests, settings_used, sb.checked);
        $display("operand extremes, zero exponents and a modulus of one were included");
        if (sb.mismatches == 0 && sb.pending_count() == 0)
            $display("modular_exponentiation_top_tb: PASS");
        else
            $display("modular_exponentiation_top_tb: FAIL");
        $finish;
    end

endmodule

FILE: sim.f
rtl/modexp_pkg.sv
rtl/modexp_mul.sv
rtl/modular_exponentiation_top.sv
sim/modular_exponentiation_top_tb.sv
